@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define SMD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define SMD_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

@@ hw/rtl/smd_pkg.sv @@
// Types and codes shared by the STUN message deframer modules.
`timescale 1ns / 1ps
`default_nettype none

package smd_pkg;

    typedef enum logic [1:0] {
        EV_HEADER = 2'd0,
        EV_ATTR   = 2'd1,
        EV_DONE   = 2'd2,
        EV_ERROR  = 2'd3
    } smd_event_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_SHORT = 2'd1,
        ERR_ALIGN = 2'd2,
        ERR_TRUNC = 2'd3
    } smd_error_t;

    localparam int HDR_BYTES  = 20;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [16:0] POS_MAX = 17'h1FFFF;
    localparam logic [17:0] OFF_MAX = 18'h3FFFF;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [15:0] class_bits;
        logic [3:0]  method_bits;
        logic [15:0] message_length;
        logic [15:0] attribute_type;
        logic [16:0] padded_length;
        logic [17:0] attribute_offset;
        logic [1:0]  error_code;
        logic        last_of_run;
    } smd_res_t;

    // Results produced by one accepted byte: zero, one or two.
    typedef struct packed {
        logic [1:0] cnt;
        smd_res_t   res0;
        smd_res_t   res1;
    } smd_push_t;

endpackage

`default_nettype wire

@@ hw/rtl/smd_parser.sv @@
// Byte-serial STUN header and attribute walk; emits up to two results per byte.
`timescale 1ns / 1ps
`default_nettype none

module smd_parser (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              byte_accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              end_of_datagram,
    output smd_pkg::smd_push_t     push
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_ATTR_HDR,
        PH_VALUE,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg,     phase_next;
    logic [4:0]  hc_reg,        hc_next;
    logic [15:0] type_reg,      type_next;
    logic [15:0] len_reg,       len_next;
    logic [16:0] pos_reg,       pos_next;
    logic [31:0] ahdr_reg,      ahdr_next;
    logic [16:0] vleft_reg,     vleft_next;
    logic [17:0] off_reg,       off_next;

    logic [4:0]  hc_inc;
    logic [16:0] pos_inc;
    logic [16:0] padded;
    logic [17:0] attr_start;
    logic [31:0] ahdr_shift;
    logic [16:0] vleft_dec;
    logic        walk_check;
    logic        finished;
    logic [1:0]  n;
    smd_pkg::smd_res_t slot [2];

    function automatic smd_pkg::smd_res_t make_res(
        input logic [1:0]  ev,
        input logic [15:0] cls,
        input logic [3:0]  meth,
        input logic [15:0] mlen,
        input logic [15:0] atype,
        input logic [16:0] plen,
        input logic [17:0] aoff,
        input logic [1:0]  err
    );
        smd_pkg::smd_res_t r;
        r.event_res        = ev;
        r.class_bits       = cls;
        r.method_bits      = meth;
        r.message_length   = mlen;
        r.attribute_type   = atype;
        r.padded_length    = plen;
        r.attribute_offset = aoff;
        r.error_code       = err;
        r.last_of_run      = 1'b0;
        return r;
    endfunction

    assign hc_inc     = hc_reg + 5'd1;
    assign pos_inc    = (pos_reg != smd_pkg::POS_MAX) ? pos_reg + 17'd1 : pos_reg;
    assign ahdr_shift = {ahdr_reg[23:0], data_byte};
    assign padded     = ({1'b0, ahdr_shift[15:0]} + 17'd3) & ~17'd3;
    assign attr_start = (off_reg >= 18'd3) ? off_reg - 18'd3 : 18'd0;
    assign vleft_dec  = (vleft_reg != 17'd0) ? vleft_reg - 17'd1 : vleft_reg;

    always_comb begin
        phase_next = phase_reg;
        hc_next    = hc_reg;
        type_next  = type_reg;
        len_next   = len_reg;
        pos_next   = pos_reg;
        ahdr_next  = ahdr_reg;
        vleft_next = vleft_reg;
        off_next   = (off_reg != smd_pkg::OFF_MAX) ? off_reg + 18'd1 : off_reg;
        walk_check = 1'b0;
        finished   = 1'b0;
        n          = 2'd0;
        slot[0]    = '0;
        slot[1]    = '0;

        if (phase_reg == PH_HEADER) begin
            if (hc_reg < 5'd2) begin
                type_next = {type_reg[7:0], data_byte};
            end else if (hc_reg < 5'd4) begin
                len_next = {len_reg[7:0], data_byte};
            end
            hc_next = hc_inc;
            if (hc_inc >= 5'(smd_pkg::HDR_BYTES)) begin
                slot[n[0]] = make_res(smd_pkg::EV_HEADER, type_next & 16'hFFF0,
                                      type_next[3:0], len_next, 16'd0, 17'd0, 18'd0,
                                      smd_pkg::ERR_NONE);
                n = n + 2'd1;
                hc_next  = 5'd0;
                pos_next = 17'd0;
                if (len_next[1:0] != 2'd0) begin
                    slot[n[0]] = make_res(smd_pkg::EV_ERROR, 16'd0, 4'd0, len_next,
                                          16'd0, 17'd0, 18'd0, smd_pkg::ERR_ALIGN);
                    n = n + 2'd1;
                    finished = 1'b1;
                end else if (len_next == 16'd0) begin
                    slot[n[0]] = make_res(smd_pkg::EV_DONE, 16'd0, 4'd0, len_next,
                                          16'd0, 17'd0, 18'd0, smd_pkg::ERR_NONE);
                    n = n + 2'd1;
                    finished = 1'b1;
                end else begin
                    phase_next = PH_ATTR_HDR;
                end
            end else if (end_of_datagram) begin
                slot[n[0]] = make_res(smd_pkg::EV_ERROR, 16'd0, 4'd0, len_next,
                                      16'd0, 17'd0, 18'd0, smd_pkg::ERR_SHORT);
                n = n + 2'd1;
                finished = 1'b1;
            end
        end else if (phase_reg == PH_ATTR_HDR) begin
            ahdr_next = ahdr_shift;
            pos_next  = pos_inc;
            hc_next   = hc_inc;
            if (hc_inc >= 5'd4) begin
                slot[n[0]] = make_res(smd_pkg::EV_ATTR, 16'd0, 4'd0, len_reg,
                                      ahdr_shift[31:16], padded, attr_start,
                                      smd_pkg::ERR_NONE);
                n = n + 2'd1;
                hc_next = 5'd0;
                if (padded == 17'd0) begin
                    walk_check = 1'b1;
                end else begin
                    vleft_next = padded;
                    phase_next = PH_VALUE;
                end
            end
        end else if (phase_reg == PH_VALUE) begin
            pos_next   = pos_inc;
            vleft_next = vleft_dec;
            if (vleft_dec == 17'd0) begin
                phase_next = PH_ATTR_HDR;
                walk_check = 1'b1;
            end
        end

        if (phase_reg != PH_SKIP) begin
            if (walk_check && (pos_next >= {1'b0, len_reg})) begin
                slot[n[0]] = make_res(smd_pkg::EV_DONE, 16'd0, 4'd0, len_reg,
                                      16'd0, 17'd0, 18'd0, smd_pkg::ERR_NONE);
                n = n + 2'd1;
                finished = 1'b1;
            end
            if (!finished && end_of_datagram && (phase_next != PH_HEADER)) begin
                slot[n[0]] = make_res(smd_pkg::EV_ERROR, 16'd0, 4'd0, len_next,
                                      16'd0, 17'd0, 18'd0, smd_pkg::ERR_TRUNC);
                n = n + 2'd1;
                finished = 1'b1;
            end
            if (finished && !end_of_datagram) begin
                phase_next = PH_SKIP;
            end
        end else begin
            // Drop bytes until the datagram ends.
            off_next = off_reg;
            finished = 1'b1;
        end

        if (n == 2'd1) begin
            slot[0].last_of_run = 1'b1;
        end else if (n == 2'd2) begin
            slot[1].last_of_run = 1'b1;
        end
    end

    assign push.cnt  = byte_accept ? n : 2'd0;
    assign push.res0 = slot[0];
    assign push.res1 = slot[1];

    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_accept && finished && end_of_datagram)) begin
            phase_reg <= PH_HEADER;
            hc_reg    <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
            ahdr_reg  <= '0;
            vleft_reg <= '0;
            off_reg   <= '0;
        end else if (byte_accept) begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            type_reg  <= type_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
            ahdr_reg  <= ahdr_next;
            vleft_reg <= vleft_next;
            off_reg   <= off_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/smd_res_fifo.sv @@
// Four-entry result queue; takes up to two results per cycle, hands out one while out_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module smd_res_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire smd_pkg::smd_push_t push,
    output logic                    room,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output smd_pkg::smd_res_t       out_res
);

    localparam int PW = $clog2(smd_pkg::QUEUE_DEPTH);

    smd_pkg::smd_res_t entry_reg [smd_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PW:0]       count_reg,  count_next;
    logic [PW-1:0]     wr_ptr_p1;
    logic              pop;

    assign pop       = out_valid && out_ready;
    assign wr_ptr_p1 = wr_ptr_reg + PW'(1);
    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];
    // Leave space for the worst case of two results from one byte.
    assign room      = (count_reg <= (PW+1)'(smd_pkg::QUEUE_DEPTH - 2));

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push.cnt);
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PW+1)'(push.cnt) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.cnt == 2'd2) begin
            entry_reg[wr_ptr_p1] <= push.res1;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/stun_message_deframer.sv @@
// Top level of the STUN message deframer: byte parser plus result queue.
//
//   channel | direction | payload                                   | handshake
//   s_      | in        | data_byte, end_of_datagram                | s_valid/s_ready
//   m_      | out       | event, class, method, lengths, type, etc. | m_valid/m_ready
//
// One byte is parsed per cycle in the cycle it is accepted; its results land in
// a four-entry queue and leave one per cycle on the m_ side from the next cycle.
// s_ready falls while fewer than two queue entries are free. With m_ready held
// high the queue never holds more than two results, so bytes go back to back;
// a stalled m_ side stalls the input once three results wait.
// aresetn is synchronous and clears the parser state and the queue.
`timescale 1ns / 1ps
`default_nettype none

module stun_message_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_datagram,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_event_res,
    output logic [15:0]      m_class_bits,
    output logic [3:0]       m_method_bits,
    output logic [15:0]      m_message_length,
    output logic [15:0]      m_attribute_type,
    output logic [16:0]      m_padded_length,
    output logic [17:0]      m_attribute_offset,
    output logic [1:0]       m_error_code,
    output logic             m_last_of_run
);

    smd_pkg::smd_push_t push;
    smd_pkg::smd_res_t  head;
    logic               room;

    assign s_ready = room;

    smd_parser u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .byte_accept     (s_valid && room),
        .data_byte       (s_data_byte),
        .end_of_datagram (s_end_of_datagram),
        .push            (push)
    );

    smd_res_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (head)
    );

    assign m_event_res        = head.event_res;
    assign m_class_bits       = head.class_bits;
    assign m_method_bits      = head.method_bits;
    assign m_message_length   = head.message_length;
    assign m_attribute_type   = head.attribute_type;
    assign m_padded_length    = head.padded_length;
    assign m_attribute_offset = head.attribute_offset;
    assign m_error_code       = head.error_code;
    assign m_last_of_run      = head.last_of_run;

endmodule

`default_nettype wire

@@ hw/rtl/smd_checker.sv @@
// Port-level checks for the STUN message deframer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module smd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [1:0]  m_event_res,
    input wire logic [15:0] m_attribute_type,
    input wire logic [16:0] m_padded_length,
    input wire logic [17:0] m_attribute_offset,
    input wire logic [1:0]  m_error_code
);

    `SMD_ASSERT(a_hold_stalled, (m_valid && !m_ready) |=> (m_valid && $stable(m_event_res) && $stable(m_error_code)), "stalled result changed")
    `SMD_ASSERT(a_err_code_match, m_valid |-> ((m_event_res == smd_pkg::EV_ERROR) == (m_error_code != smd_pkg::ERR_NONE)), "error code disagrees with event")
    `SMD_ASSERT(a_pad_aligned, m_valid |-> (m_padded_length[1:0] == 2'd0), "padded length not aligned")
    `SMD_ASSERT(a_attr_offset, (m_valid && (m_event_res == smd_pkg::EV_ATTR)) |-> (m_attribute_offset >= 18'd20), "attribute inside header")
    `SMD_NEVER(a_hdr_clean, m_valid && (m_event_res == smd_pkg::EV_HEADER) && ((m_attribute_type != 16'd0) || (m_padded_length != 17'd0)), "header event carries attribute fields")

endmodule

bind stun_message_deframer smd_checker u_smd_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_event_res        (m_event_res),
    .m_attribute_type   (m_attribute_type),
    .m_padded_length    (m_padded_length),
    .m_attribute_offset (m_attribute_offset),
    .m_error_code       (m_error_code)
);

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the STUN message deframer: directed and random datagrams.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BYTES  = 500;
    localparam int STALL_CYCLES  = 400;
    localparam int SETTLE_CYCLES = 16;

    typedef enum logic [1:0] {
        WALK_HEADER,
        WALK_ATTR_HDR,
        WALK_VALUE,
        WALK_SKIP
    } walk_phase_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_HALF,
        RX_SPARSE,
        RX_ALTERNATE
    } rx_pattern_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_end_of_datagram = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_event_res;
    logic [15:0] m_class_bits;
    logic [3:0]  m_method_bits;
    logic [15:0] m_message_length;
    logic [15:0] m_attribute_type;
    logic [16:0] m_padded_length;
    logic [17:0] m_attribute_offset;
    logic [1:0]  m_error_code;
    logic        m_last_of_run;

    stun_message_deframer u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .s_end_of_datagram  (s_end_of_datagram),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_event_res        (m_event_res),
        .m_class_bits       (m_class_bits),
        .m_method_bits      (m_method_bits),
        .m_message_length   (m_message_length),
        .m_attribute_type   (m_attribute_type),
        .m_padded_length    (m_padded_length),
        .m_attribute_offset (m_attribute_offset),
        .m_error_code       (m_error_code),
        .m_last_of_run      (m_last_of_run)
    );

    // Parser state mirrored by the predictor
    walk_phase_t walk_phase;
    logic [4:0]  hdr_cnt;
    logic [15:0] hdr_type;
    logic [15:0] msg_len;
    logic [16:0] body_pos;
    logic [31:0] attr_word;
    logic [16:0] value_left;
    logic [17:0] dgram_off;

    smd_pkg::smd_res_t expected_events[$];
    logic [7:0]        frame_bytes[$];

    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    bit          gaps_on = 1'b1;
    int          hold_request = 0;
    int          hold_left = 0;
    int          pattern_left = 0;
    rx_pattern_t rx_pattern = RX_ALWAYS;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic void clear_walk();
        walk_phase = WALK_HEADER;
        hdr_cnt    = '0;
        hdr_type   = '0;
        msg_len    = '0;
        body_pos   = '0;
        attr_word  = '0;
        value_left = '0;
        dgram_off  = '0;
    endfunction

    function automatic void add_event(input smd_pkg::smd_event_t ev, input logic [15:0] cls,
                                      input logic [3:0] meth, input logic [15:0] atype,
                                      input logic [16:0] plen, input logic [17:0] aoff,
                                      input smd_pkg::smd_error_t err);
        smd_pkg::smd_res_t r;
        r.event_res        = ev;
        r.class_bits       = cls;
        r.method_bits      = meth;
        r.message_length   = msg_len;
        r.attribute_type   = atype;
        r.padded_length    = plen;
        r.attribute_offset = aoff;
        r.error_code       = err;
        r.last_of_run      = 1'b0;
        expected_events.insert(expected_events.size(), r);
    endfunction

    function automatic void predict_byte(input logic [7:0] value, input logic eod);
        int          n;
        logic        finished;
        logic        walk_check;
        logic [16:0] padded;
        logic [17:0] start;
        n = 0;
        finished = 1'b0;
        walk_check = 1'b0;
        // drop everything after done or error until the datagram ends
        if (walk_phase == WALK_SKIP) begin
            if (eod)
                clear_walk();
            return;
        end
        case (walk_phase)
            WALK_HEADER: begin
                if (hdr_cnt < 5'd2)
                    hdr_type = {hdr_type[7:0], value};
                else if (hdr_cnt < 5'd4)
                    msg_len = {msg_len[7:0], value};
                hdr_cnt = hdr_cnt + 5'd1;
                if (hdr_cnt >= 5'(smd_pkg::HDR_BYTES)) begin
                    add_event(smd_pkg::EV_HEADER, hdr_type & 16'hFFF0, hdr_type[3:0],
                              '0, '0, '0, smd_pkg::ERR_NONE);
                    n++;
                    hdr_cnt = '0;
                    body_pos = '0;
                    if (msg_len[1:0] != 2'b00) begin
                        add_event(smd_pkg::EV_ERROR, '0, '0, '0, '0, '0, smd_pkg::ERR_ALIGN);
                        n++;
                        finished = 1'b1;
                    end else if (msg_len == 16'h0000) begin
                        add_event(smd_pkg::EV_DONE, '0, '0, '0, '0, '0, smd_pkg::ERR_NONE);
                        n++;
                        finished = 1'b1;
                    end else begin
                        walk_phase = WALK_ATTR_HDR;
                    end
                end else if (eod) begin
                    add_event(smd_pkg::EV_ERROR, '0, '0, '0, '0, '0, smd_pkg::ERR_SHORT);
                    n++;
                    finished = 1'b1;
                end
            end
            WALK_ATTR_HDR: begin
                attr_word = {attr_word[23:0], value};
                if (body_pos != smd_pkg::POS_MAX)
                    body_pos = body_pos + 17'd1;
                hdr_cnt = hdr_cnt + 5'd1;
                if (hdr_cnt >= 5'd4) begin
                    padded = ({1'b0, attr_word[15:0]} + 17'd3) & ~17'd3;
                    start = (dgram_off >= 18'd3) ? dgram_off - 18'd3 : 18'd0;
                    add_event(smd_pkg::EV_ATTR, '0, '0, attr_word[31:16], padded, start,
                              smd_pkg::ERR_NONE);
                    n++;
                    hdr_cnt = '0;
                    if (padded == '0) begin
                        walk_check = 1'b1;
                    end else begin
                        value_left = padded;
                        walk_phase = WALK_VALUE;
                    end
                end
            end
            default: begin
                if (body_pos != smd_pkg::POS_MAX)
                    body_pos = body_pos + 17'd1;
                if (value_left != '0)
                    value_left = value_left - 17'd1;
                if (value_left == '0) begin
                    walk_phase = WALK_ATTR_HDR;
                    walk_check = 1'b1;
                end
            end
        endcase
        if (walk_check && body_pos >= {1'b0, msg_len}) begin
            add_event(smd_pkg::EV_DONE, '0, '0, '0, '0, '0, smd_pkg::ERR_NONE);
            n++;
            finished = 1'b1;
        end
        if (!finished && eod && walk_phase != WALK_HEADER) begin
            add_event(smd_pkg::EV_ERROR, '0, '0, '0, '0, '0, smd_pkg::ERR_TRUNC);
            n++;
            finished = 1'b1;
        end
        if (dgram_off != smd_pkg::OFF_MAX)
            dgram_off = dgram_off + 18'd1;
        if (finished) begin
            if (eod)
                clear_walk();
            else
                walk_phase = WALK_SKIP;
        end
        if (n > 0)
            expected_events[expected_events.size() - 1].last_of_run = 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [17:0] want,
                                        input logic [17:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Predict on every accepted byte, then compare every accepted result
    always @(posedge aclk) begin : monitor
        smd_pkg::smd_res_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                predict_byte(s_data_byte, s_end_of_datagram);
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $error("result with nothing expected: event_res 0x%0h", m_event_res);
                    mismatch_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("event_res", 18'(want.event_res), 18'(m_event_res));
                    check_field("class_bits", 18'(want.class_bits), 18'(m_class_bits));
                    check_field("method_bits", 18'(want.method_bits), 18'(m_method_bits));
                    check_field("message_length", 18'(want.message_length),
                                18'(m_message_length));
                    check_field("attribute_type", 18'(want.attribute_type),
                                18'(m_attribute_type));
                    check_field("padded_length", 18'(want.padded_length),
                                18'(m_padded_length));
                    check_field("attribute_offset", want.attribute_offset,
                                m_attribute_offset);
                    check_field("error_code", 18'(want.error_code), 18'(m_error_code));
                    check_field("last_of_run", 18'(want.last_of_run), 18'(m_last_of_run));
                end
            end
        end
    end

    // Receiver: random ready patterns, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    rx_pattern = rx_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(20, 150);
                end
                pattern_left--;
                case (rx_pattern)
                    RX_ALWAYS:    m_ready <= 1'b1;
                    RX_HALF:      m_ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE:    m_ready <= ($urandom_range(0, 4) == 0);
                    RX_ALTERNATE: m_ready <= ~m_ready;
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        if (gaps_on && burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        s_valid <= 1'b1;
        s_data_byte <= value;
        s_end_of_datagram <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (expected_events.size() != 0);
    endtask

    function automatic void add_bytes(input int count);
        int i;
        for (i = 0; i < count; i++)
            frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
    endfunction

    // Header with random cookie and transaction id
    function automatic void start_frame(input logic [15:0] msg_kind, input logic [15:0] len);
        frame_bytes.delete();
        frame_bytes.insert(frame_bytes.size(), msg_kind[15:8]);
        frame_bytes.insert(frame_bytes.size(), msg_kind[7:0]);
        frame_bytes.insert(frame_bytes.size(), len[15:8]);
        frame_bytes.insert(frame_bytes.size(), len[7:0]);
        add_bytes(smd_pkg::HDR_BYTES - 4);
    endfunction

    function automatic void add_attr(input logic [15:0] atype, input logic [15:0] alen,
                                     input int value_count);
        frame_bytes.insert(frame_bytes.size(), atype[15:8]);
        frame_bytes.insert(frame_bytes.size(), atype[7:0]);
        frame_bytes.insert(frame_bytes.size(), alen[15:8]);
        frame_bytes.insert(frame_bytes.size(), alen[7:0]);
        add_bytes(value_count);
    endfunction

    // Valid attribute walk; optionally declare one word less than the walk covers
    function automatic void build_wellformed(input bit overshoot);
        int n_attr;
        int alen[4];
        int body;
        int i;
        n_attr = $urandom_range(0, 4);
        body = 0;
        for (i = 0; i < n_attr; i++) begin
            alen[i] = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 120)
                                                   : $urandom_range(0, 12);
            body += 4 + ((alen[i] + 3) & ~3);
        end
        if (overshoot && n_attr > 0 && alen[n_attr - 1] > 0)
            body -= 4;
        start_frame(16'($urandom_range(0, 65535)), 16'(body));
        for (i = 0; i < n_attr; i++)
            add_attr(16'($urandom_range(0, 65535)), 16'(alen[i]), (alen[i] + 3) & ~3);
    endfunction

    task automatic test_short_header();
        frame_bytes.delete();
        frame_bytes.insert(0, 8'hFF);
        send_frame();
        start_frame(16'h0001, 16'h0008);
        void'(frame_bytes.pop_back());
        send_frame();
    endtask

    task automatic test_empty_body();
        start_frame(16'hFFFF, 16'h0000);
        send_frame();
        start_frame(16'h0000, 16'h0000);
        send_frame();
    endtask

    task automatic test_bad_length();
        start_frame(16'h0101, 16'h0001);
        add_bytes(3);
        send_frame();
        start_frame(16'h1234, 16'hFFFF);
        send_frame();
    endtask

    task automatic test_attribute_walk();
        start_frame(16'h0001, 16'd28);
        add_attr(16'h0000, 16'd0, 0);
        add_attr(16'hFFFF, 16'd1, 4);
        add_attr(16'h8028, 16'd12, 12);
        send_frame();
        // zero-length attribute closes the walk on its own header
        start_frame(16'h0111, 16'd4);
        add_attr(16'h0020, 16'd0, 0);
        send_frame();
    endtask

    task automatic test_truncated_body();
        start_frame(16'h0101, 16'd8);
        send_frame();
        start_frame(16'h0001, 16'd8);
        add_bytes(2);
        send_frame();
        start_frame(16'h0001, 16'hFFFC);
        add_attr(16'h0006, 16'hFFFF, 2);
        send_frame();
    endtask

    task automatic test_overshoot();
        start_frame(16'h0001, 16'd4);
        add_attr(16'h0024, 16'd8, 8);
        add_bytes(5);
        send_frame();
    endtask

    task automatic test_trailing_bytes();
        start_frame(16'h0113, 16'd8);
        add_attr(16'h8022, 16'd3, 4);
        add_bytes(7);
        send_frame();
        start_frame(16'h0001, 16'd0);
        send_frame();
    endtask

    task automatic test_output_stall();
        int i;
        wait_for_results();
        gaps_on = 1'b0;
        hold_request = STALL_CYCLES;
        for (i = 0; i < 3; i++) begin
            start_frame(16'($urandom_range(0, 65535)), 16'h0000);
            send_frame();
        end
        build_wellformed(1'b0);
        send_frame();
        wait_for_results();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int useful_bytes;
        int kind;
        useful_bytes = 0;
        while (useful_bytes < RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            gaps_on = ($urandom_range(0, 3) != 0);
            if (kind < 65) begin
                build_wellformed(1'b0);
            end else if (kind < 72) begin
                frame_bytes.delete();
                add_bytes($urandom_range(1, smd_pkg::HDR_BYTES - 1));
            end else if (kind < 79) begin
                start_frame(16'($urandom_range(0, 65535)),
                            16'(($urandom_range(0, 65535) & 16'hFFFC) | $urandom_range(1, 3)));
            end else if (kind < 88) begin
                build_wellformed(1'b0);
                if (frame_bytes.size() > smd_pkg::HDR_BYTES)
                    repeat ($urandom_range(1, frame_bytes.size() - smd_pkg::HDR_BYTES))
                        void'(frame_bytes.pop_back());
            end else if (kind < 95) begin
                build_wellformed(1'b1);
            end else begin
                frame_bytes.delete();
                add_bytes($urandom_range(smd_pkg::HDR_BYTES, 60));
            end
            useful_bytes += frame_bytes.size();
            if ($urandom_range(0, 2) == 0)
                add_bytes($urandom_range(1, 5));
            send_frame();
            if ($urandom_range(0, 14) == 0)
                wait_for_results();
        end
    endtask

    initial begin
        clear_walk();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_short_header();
        test_empty_body();
        test_bad_length();
        test_attribute_walk();
        test_truncated_body();
        test_overshoot();
        test_trailing_bytes();
        test_output_stall();
        test_random_traffic();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
